FILE: rtl/annealed_gradient_ascent_step_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gradient ascent step block
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ANNEALED_GRADIENT_ASCENT_STEP_DEFINES_SVH
`define ANNEALED_GRADIENT_ASCENT_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define AGAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define AGAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked during reset.
`define AGAS_ASSERT_ALW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/agas_pkg.sv
// ----------------------------------------------------------------------------
// agas_pkg
// Widths, register indexes, controller states and control bundles.
// ----------------------------------------------------------------------------
package agas_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned TempW    = 17;
  localparam int unsigned CountW   = 16;
  localparam int unsigned LimitW   = 31;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 120;

  // Restoring divider retires two quotient bits per cycle over a 50-bit dividend.
  localparam int unsigned NumW      = 50;
  localparam int unsigned DivSteps  = NumW / 2;
  localparam int unsigned DivCntW   = 5;

  localparam logic [TempW-1:0]  TempOne  = 17'd65536;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  localparam logic [CfgAddrW-1:0] RegDerivTol   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegTempFloor  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegTempFactor = 3'd2;
  localparam logic [CfgAddrW-1:0] RegTargetVal  = 3'd3;
  localparam logic [CfgAddrW-1:0] RegTargetMarg = 3'd4;
  localparam logic [CfgAddrW-1:0] RegIterLimit  = 3'd5;
  localparam logic [CfgAddrW-1:0] RegStepLimit  = 3'd6;

  localparam logic ModeStart = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MLO,
    ST_MHI,
    ST_SUM,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic ddx_zero;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/agas_ctrl.sv
// ----------------------------------------------------------------------------
// agas_ctrl
// Sequencer: load, prepare, divide, two partial multiplies, clamp, finish.
// ----------------------------------------------------------------------------
module agas_ctrl import agas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t             state_r, state_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: begin
        cnt_nxt   = '0;
        state_nxt = sts.ddx_zero ? ST_SUM : ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivSteps - 1)) state_nxt = ST_MLO;
      end
      ST_MLO: state_nxt = ST_MHI;
      ST_MHI: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_FIN;
      ST_FIN: if (!sts.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd        = '0;
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.prep   = (state_r == ST_PREP);
    cmd.div    = (state_r == ST_DIV);
    cmd.mul_lo = (state_r == ST_MLO);
    cmd.mul_hi = (state_r == ST_MHI);
    cmd.sum    = (state_r == ST_SUM);
    cmd.fin    = (state_r == ST_FIN) && !sts.out_busy;
  end

endmodule

FILE: rtl/agas_dp.sv
// ----------------------------------------------------------------------------
// agas_dp
// State, configuration registers, divider, multipliers and output register.
// ----------------------------------------------------------------------------
module agas_dp import agas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                in_mode,
  input  logic [InDataW-1:0]  in_data,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [DataW-1:0]    cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OutDataW-1:0] out_data
);

  logic [LimitW-1:0] tol_r, step_lim_r;
  logic [TempW-1:0]  floor_r, factor_r;
  logic [DataW-1:0]  tval_r, tmarg_r;
  logic [CountW-1:0] iter_lim_r;

  logic [DataW-1:0]  cur_x_r, prev_x_r, cur_d_r, prev_d_r, cur_v_r, prop_r;
  logic [TempW-1:0]  temp_r;
  logic [CountW-1:0] cnt_r;

  logic [33:0]       rem_r, rem_nxt;
  logic [NumW-1:0]   quo_r, quo_nxt;
  logic [32:0]       den_r;
  logic [55:0]       plo_r;
  logic [54:0]       phi_r;
  logic [LimitW-1:0] m_r;
  logic              neg_r;

  logic              out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  logic [33:0] xsum;
  logic [31:0] next_x;

  logic [DataW-1:0] in_x, in_xp, in_v, in_d, in_dp;
  assign in_x  = in_data[31:0];
  assign in_xp = in_data[63:32];
  assign in_v  = in_data[95:64];
  assign in_d  = in_data[127:96];
  assign in_dp = in_data[159:128];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= 31'd65;
      floor_r    <= 17'd66;
      factor_r   <= 17'd32768;
      tval_r     <= '0;
      tmarg_r    <= '0;
      iter_lim_r <= 16'd100;
      step_lim_r <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegDerivTol:   tol_r      <= cfg_wdata[LimitW-1:0];
        RegTempFloor:  floor_r    <= cfg_wdata[TempW-1:0];
        RegTempFactor: factor_r   <= cfg_wdata[TempW-1:0];
        RegTargetVal:  tval_r     <= cfg_wdata;
        RegTargetMarg: tmarg_r    <= cfg_wdata;
        RegIterLimit:  iter_lim_r <= cfg_wdata[CountW-1:0];
        RegStepLimit:  step_lim_r <= cfg_wdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Temperature is scaled by the factor only when the three-valued derivative sign changes.
  logic        flip;
  logic [33:0] tprod;
  logic [17:0] tscaled;
  assign flip = ((cur_d_r == '0) != (in_d == '0)) || (cur_d_r[31] != in_d[31]);
  assign tprod = 34'(temp_r) * 34'(factor_r);
  assign tscaled = tprod[33:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      prev_x_r <= '0;
      cur_d_r  <= '0;
      prev_d_r <= '0;
      cur_v_r  <= '0;
      prop_r   <= '0;
      temp_r   <= TempOne;
      cnt_r    <= '0;
    end else if (cmd.load) begin
      if (in_mode == ModeStart) begin
        cur_x_r  <= in_x;
        prev_x_r <= in_xp;
        cur_v_r  <= in_v;
        cur_d_r  <= in_d;
        prev_d_r <= in_dp;
        temp_r   <= TempOne;
        cnt_r    <= '0;
      end else begin
        prev_x_r <= cur_x_r;
        prev_d_r <= cur_d_r;
        cur_x_r  <= prop_r;
        cur_d_r  <= in_d;
        cur_v_r  <= in_v;
        if (flip) temp_r <= tscaled[17] ? {TempW{1'b1}} : tscaled[TempW-1:0];
        if (cnt_r != CountMax) cnt_r <= cnt_r + 1'b1;
      end
    end else if (cmd.fin) begin
      prop_r <= next_x;
    end
  end

  logic [32:0] dx, ddx, adx;
  logic [31:0] dmag;
  assign dx   = {cur_x_r[31], cur_x_r} - {prev_x_r[31], prev_x_r};
  assign ddx  = {cur_d_r[31], cur_d_r} - {prev_d_r[31], prev_d_r};
  assign adx  = dx[32] ? (33'd0 - dx) : dx;
  assign dmag = cur_d_r[31] ? (32'd0 - cur_d_r) : cur_d_r;
  assign sts.ddx_zero = (cur_d_r == prev_d_r);

  // Two restoring steps per cycle; the quotient shifts in behind the dividend.
  always_comb begin
    logic [33:0] r;
    logic [NumW-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < 2; i++) begin
      r = {r[32:0], q[NumW-1]};
      q = {q[NumW-2:0], 1'b0};
      if (r >= {1'b0, den_r}) begin
        r = r - {1'b0, den_r};
        q[0] = 1'b1;
      end
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  logic [78:0] full;
  logic [62:0] mq;
  logic [LimitW-1:0] m_sel;
  assign full = {phi_r, 24'd0} + {23'd0, plo_r};
  assign mq   = full[78:16];

  always_comb begin
    if (sts.ddx_zero)             m_sel = step_lim_r;
    else if (dmag == '0)          m_sel = '0;
    else if (|quo_r[NumW-1:47])   m_sel = step_lim_r;
    else if (mq > 63'(step_lim_r)) m_sel = step_lim_r;
    else                          m_sel = mq[LimitW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo_r <= NumW'(temp_r) * NumW'(adx);
      den_r <= ddx[32] ? (33'd0 - ddx) : ddx;
      rem_r <= '0;
    end else if (cmd.div) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.mul_lo) plo_r <= 56'(quo_r[23:0]) * 56'(dmag);
    if (cmd.mul_hi) phi_r <= 55'(quo_r[46:24]) * 55'(dmag);
    if (cmd.sum) begin
      m_r   <= m_sel;
      neg_r <= !sts.ddx_zero && cur_d_r[31];
    end
  end

  assign xsum = neg_r ? ({{2{cur_x_r[31]}}, cur_x_r} - {3'd0, m_r})
                      : ({{2{cur_x_r[31]}}, cur_x_r} + {3'd0, m_r});
  always_comb begin
    if (xsum[33:31] == 3'b000 || xsum[33:31] == 3'b111) next_x = xsum[31:0];
    else if (xsum[33])                                  next_x = 32'h8000_0000;
    else                                                next_x = 32'h7FFF_FFFF;
  end

  logic        keep;
  logic [33:0] gap;
  assign gap  = {{2{tval_r[31]}}, tval_r} - {{2{cur_v_r[31]}}, cur_v_r};
  assign keep = (dmag > {1'b0, tol_r}) && (temp_r > floor_r) &&
                ((tval_r == tmarg_r) ||
                 ($signed(gap) > $signed({{2{tmarg_r[31]}}, tmarg_r}))) &&
                (cnt_r < iter_lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) out_data_r <= {7'd0, cnt_r, cur_v_r, cur_x_r, keep, next_x};
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

FILE: rtl/annealed_gradient_ascent_step.sv
// ----------------------------------------------------------------------------
// annealed_gradient_ascent_step
// One-dimensional Barzilai-Borwein gradient ascent step in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: send a start word (in_tuser = 0) with the initial points, value and
// derivatives, then one step word (in_tuser = 1) per evaluation of the
// proposed x. Every input word yields one output word with the next x to
// evaluate, the continue flag and the current point, value and step count.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; write them only
// while idle, as the block does not enforce it. A word passes through the
// prepare, divide, two partial multiply, clamp and finish states; if the
// derivative did not change, divide and multiplies are skipped. The radix-4
// restoring divider gives the step size; one word is in flight at a time.
// in_tready is high whenever the block is idle, including while an earlier
// result still waits in the output register. If the receiver stalls, the
// block finishes the next word and holds in its last state until the
// output register frees. Synchronous reset restores the register defaults,
// clears the history, sets the temperature to 1.0 and drops out_tvalid.
// ----------------------------------------------------------------------------
module annealed_gradient_ascent_step import agas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // x_point, x_previous, value, derivative, derivative_previous
  input  logic [InDataW-1:0]  in_tdata,
  // mode
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // next_x, keep_going, current_x, current_value, steps_done, zero fill
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [DataW-1:0]    cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  agas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  agas_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

FILE: rtl/agas_checker.sv
// ----------------------------------------------------------------------------
// agas_checker
// Port-level checks on the gradient ascent step block.
// ----------------------------------------------------------------------------
`include "annealed_gradient_ascent_step_defines.svh"

module agas_checker import agas_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // A stalled result word keeps its contents.
  `AGAS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output word changed")

  // One word is worked on at a time.
  `AGAS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted while busy")

  // A new result appears only at the end of a computation.
  `AGAS_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result without work")

  // Reset empties the output register.
  `AGAS_ASSERT_ALW(a_reset_clears, clk, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind annealed_gradient_ascent_step agas_checker u_agas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/tb_annealed_gradient_ascent_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gradient ascent step testbench
// Sends start and step words with random content under random input gaps and
// output stalls, predicts every result word in fixed point and compares it
// field by field. Several register settings are run, the extremes included.
// ----------------------------------------------------------------------------
module tb_annealed_gradient_ascent_step;
  import agas_pkg::*;

  localparam int unsigned RunLimit  = 1000000;
  localparam int unsigned DrainWait = 40;

  typedef struct {
    logic       mode;
    logic [31:0] x_point;
    logic [31:0] x_prev;
    logic [31:0] value;
    logic [31:0] deriv;
    logic [31:0] deriv_prev;
  } step_word_t;

  typedef struct {
    logic [31:0] next_x;
    logic        keep_going;
    logic [31:0] cur_x;
    logic [31:0] cur_value;
    logic [15:0] steps;
  } ascent_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [DataW-1:0]    cfg_wdata;

  annealed_gradient_ascent_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Register copies.
  int unsigned deriv_tol;
  int unsigned temp_floor;
  int unsigned temp_factor;
  int          target_val;
  int          target_marg;
  int unsigned iter_limit;
  int unsigned step_limit;

  // Block state copies.
  int          cur_x;
  int          prev_x;
  int          cur_deriv;
  int          prev_deriv;
  int          cur_value;
  int          proposal;
  int unsigned temperature;
  int unsigned step_count;

  step_word_t     pending_words[$];
  ascent_result_t expected_results[$];
  int unsigned    mismatches;
  int unsigned    words_seen;
  int unsigned    cycles;
  int          gen_deriv;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int sign3(int v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic int next_proposal();
    longint          dx;
    longint          ddx;
    longint          offset;
    longint          sum;
    longint unsigned gamma;
    longint unsigned d;
    longint unsigned m;
    dx = longint'(cur_x) - longint'(prev_x);
    ddx = longint'(cur_deriv) - longint'(prev_deriv);
    if (ddx == 0) begin
      offset = longint'(step_limit);
    end else begin
      gamma = (longint'(temperature) * mag(dx)) / mag(ddx);
      d = mag(longint'(cur_deriv));
      if (d == 0) begin
        m = 0;
      end else if (gamma >= (64'd1 << 47)) begin
        m = step_limit;
      end else begin
        m = gamma * (d >> 16) + ((gamma * (d & 64'hFFFF)) >> 16);
        if (m > step_limit) m = step_limit;
      end
      offset = (cur_deriv < 0) ? -longint'(m) : longint'(m);
    end
    sum = longint'(cur_x) + offset;
    if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
    if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
    return int'(sum);
  endfunction

  task automatic predict_step(input step_word_t w);
    ascent_result_t  r;
    longint unsigned t;
    bit              keep;
    if (w.mode == ModeStart) begin
      cur_x = w.x_point;
      prev_x = w.x_prev;
      cur_value = w.value;
      cur_deriv = w.deriv;
      prev_deriv = w.deriv_prev;
      temperature = 65536;
      step_count = 0;
    end else begin
      prev_x = cur_x;
      prev_deriv = cur_deriv;
      cur_x = proposal;
      cur_deriv = w.deriv;
      cur_value = w.value;
      if (sign3(prev_deriv) != sign3(cur_deriv)) begin
        t = (longint'(temperature) * temp_factor) >> 16;
        temperature = (t > 'h1FFFF) ? 'h1FFFF : int'(t);
      end
      if (step_count < 'hFFFF) step_count++;
    end
    proposal = next_proposal();
    keep = (mag(longint'(cur_deriv)) > deriv_tol) && (temperature > temp_floor) &&
           ((target_val == target_marg) ||
            (longint'(target_val) - longint'(cur_value) > longint'(target_marg))) &&
           (step_count < iter_limit);
    r.next_x = proposal;
    r.keep_going = keep;
    r.cur_x = cur_x;
    r.cur_value = cur_value;
    r.steps = step_count[15:0];
    expected_results.push_back(r);
  endtask

  // Input driver: bursts of random length separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  step_word_t  on_bus;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_step(on_bus);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          on_bus = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= on_bus.mode;
          in_tdata <= {on_bus.deriv_prev, on_bus.deriv, on_bus.value,
                       on_bus.x_prev, on_bus.x_point};
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 15);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off.
  int unsigned stall_kind;
  int unsigned hold_left;
  bit          hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_kind <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_kind <= $urandom_range(0, 3);
      if (!hold_done && words_seen == 300) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (stall_kind)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          2: out_tready <= ($urandom_range(0, 9) < 2);
          default: out_tready <= ($urandom_range(0, 31) != 0);
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    ascent_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen <= words_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        e = expected_results.pop_front();
        if (out_tdata[31:0] !== e.next_x || out_tdata[32] !== e.keep_going ||
            out_tdata[64:33] !== e.cur_x || out_tdata[96:65] !== e.cur_value ||
            out_tdata[112:97] !== e.steps || out_tdata[119:113] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch word %0d: next_x %h/%h keep %b/%b x %h/%h val %h/%h n %0d/%0d",
                     words_seen, e.next_x, out_tdata[31:0], e.keep_going, out_tdata[32],
                     e.cur_x, out_tdata[64:33], e.cur_value, out_tdata[96:65],
                     e.steps, out_tdata[112:97]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      RegDerivTol:   deriv_tol = val & 32'h7FFF_FFFF;
      RegTempFloor:  temp_floor = val & 32'h1FFFF;
      RegTempFactor: temp_factor = val & 32'h1FFFF;
      RegTargetVal:  target_val = val;
      RegTargetMarg: target_marg = val;
      RegIterLimit:  iter_limit = val & 32'hFFFF;
      RegStepLimit:  step_limit = val & 32'h7FFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] tol, input logic [31:0] flr,
                           input logic [31:0] fac, input logic [31:0] tv,
                           input logic [31:0] tm, input logic [31:0] itl,
                           input logic [31:0] stl);
    write_reg(RegDerivTol, tol);
    write_reg(RegTempFloor, flr);
    write_reg(RegTempFactor, fac);
    write_reg(RegTargetVal, tv);
    write_reg(RegTargetMarg, tm);
    write_reg(RegIterLimit, itl);
    write_reg(RegStepLimit, stl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic push(input logic mode, input logic [31:0] xp, input logic [31:0] xq,
                      input logic [31:0] v, input logic [31:0] d, input logic [31:0] dp);
    step_word_t w;
    w.mode = mode;
    w.x_point = xp;
    w.x_prev = xq;
    w.value = v;
    w.deriv = d;
    w.deriv_prev = dp;
    pending_words.push_back(w);
    gen_deriv = d;
  endtask

  function automatic logic [31:0] pick_deriv();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return gen_deriv;
      2: return $urandom;
      3: return -gen_deriv;
      4: return $urandom_range(1, 200) - 100;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_point();
    return ($urandom_range(0, 4) == 0) ? $urandom
                                       : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
  endfunction

  // Mostly a start word, then a run of step words, with unused fields left random.
  task automatic push_runs(input int unsigned count);
    int unsigned n;
    int unsigned run_len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) != 0) begin
        push(ModeStart, pick_point(), pick_point(), pick_point(), pick_deriv(), pick_deriv());
        n++;
      end
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (run_len) begin
        push(~ModeStart, $urandom, $urandom, pick_point(), pick_deriv(), $urandom);
        n++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    words_seen = 0;
    cycles = 0;
    gen_deriv = 0;
    deriv_tol = 65;
    temp_floor = 66;
    temp_factor = 32768;
    target_val = 0;
    target_marg = 0;
    iter_limit = 100;
    step_limit = 65536;
    cur_x = 0;
    prev_x = 0;
    cur_deriv = 0;
    prev_deriv = 0;
    cur_value = 0;
    proposal = 0;
    temperature = 65536;
    step_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under reset defaults: a step before any start, field
    // extremes, zero derivative change, zero derivative and sign flips.
    push(~ModeStart, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push(ModeStart, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push(~ModeStart, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push(ModeStart, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push(~ModeStart, 32'h0, 32'h0, 32'h0001_0000, 32'h8000_0000, 32'h0);
    push(ModeStart, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000);
    push(~ModeStart, 32'h0, 32'h0, 32'h0000_8000, 32'hFFFF_0000, 32'h0);
    push(~ModeStart, 32'h0, 32'h0, 32'h0000_9000, 32'h0000_0800, 32'h0);
    push(~ModeStart, 32'h0, 32'h0, 32'h0000_9000, 32'h0000_0800, 32'h0);
    push(~ModeStart, 32'h0, 32'h0, 32'h0000_A000, 32'h0, 32'h0);
    push(~ModeStart, 32'h0, 32'h0, 32'h0000_A000, 32'h0000_0041, 32'h0);
    push(~ModeStart, 32'h0, 32'h0, 32'h0000_A000, 32'h0000_0040, 32'h0);
    push(ModeStart, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0);
    push(ModeStart, 32'h7FFF_0000, 32'h0, 32'h0, 32'h0100_0000, 32'h0);
    push(~ModeStart, 32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0);
    push_runs(220);
    wait_drained();

    write_all(32'h0, 32'h0, 32'h10000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF,
              32'h7FFF_FFFF);
    push(ModeStart, 32'h0, 32'h0, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
    push_runs(220);
    wait_drained();

    write_all(32'h7FFF_FFFF, 32'h10000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
              32'h0);
    push_runs(220);
    wait_drained();

    repeat (3) begin
      write_all($urandom & 32'h7FFF_FFFF, $urandom_range(0, 65536),
                $urandom_range(0, 65536), $urandom, $urandom, $urandom_range(0, 65535),
                ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h0004_0000)
                                            : ($urandom & 32'h7FFF_FFFF));
      push_runs(230);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
